// ===== src/dcf_pkg.sv =====
// Shared constants and types for the decimating complex FIR filter.
package dcf_pkg;

    localparam int DEF_MAX_TAPS    = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int COEF_BITS  = 16;
    localparam int FRAC_BITS  = 15;
    localparam int IDX_BITS   = 6;
    localparam int DECIM_BITS = 9;
    localparam int TAPS_BITS  = 7;
    localparam int PHASE_BITS = 8;
    localparam int MAX_DECIM  = 256;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 9;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DECIMATION = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_COUNT  = 1'b1;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    typedef struct packed {
        logic clear;
        logic valid;
        logic last;
    } mac_ctrl_t;

endpackage

// ===== src/dcf_mac.sv =====
// Complex-by-real multiply-accumulate unit with rounding and saturation.
module dcf_mac #(
    parameter int MAX_TAPS    = dcf_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = dcf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dcf_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [dcf_pkg::COEF_BITS-1:0] coef,
    input  logic signed [SAMPLE_BITS-1:0]        smp_i,
    input  logic signed [SAMPLE_BITS-1:0]        smp_q,
    output logic                                 res_valid,
    output logic signed [SAMPLE_BITS-1:0]        res_i,
    output logic signed [SAMPLE_BITS-1:0]        res_q,
    output logic                                 res_clipped
);

    localparam int PROD_W = SAMPLE_BITS + dcf_pkg::COEF_BITS;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int V_W    = ACC_W + 1;

    localparam logic signed [V_W-1:0] HALF = V_W'(2 ** (dcf_pkg::FRAC_BITS - 1));
    localparam logic [SAMPLE_BITS-1:0] HI  = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] LO  = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    logic signed [PROD_W-1:0] prod_i_reg;
    logic signed [PROD_W-1:0] prod_q_reg;
    logic                     valid_a_reg;
    logic                     last_a_reg;
    logic signed [ACC_W-1:0]  acc_i_reg;
    logic signed [ACC_W-1:0]  acc_q_reg;
    logic                     done_b_reg;
    logic [SAMPLE_BITS:0]     rnd_i;
    logic [SAMPLE_BITS:0]     rnd_q;
    logic                     res_valid_reg;
    logic signed [SAMPLE_BITS-1:0] res_i_reg;
    logic signed [SAMPLE_BITS-1:0] res_q_reg;
    logic                     res_clipped_reg;

    // Returns {clipped, value}: round half up by the fraction bits, then clip.
    function automatic logic [SAMPLE_BITS:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [V_W-1:0] v;
        logic signed [V_W-1:0] q;
        logic                  fits;
        v    = V_W'(a) + HALF;
        q    = v >>> dcf_pkg::FRAC_BITS;
        fits = (&q[V_W-1:SAMPLE_BITS-1]) || !(|q[V_W-1:SAMPLE_BITS-1]);
        if (fits)
        begin
            round_sat = {1'b0, q[SAMPLE_BITS-1:0]};
        end
        else if (q[V_W-1])
        begin
            round_sat = {1'b1, LO};
        end
        else
        begin
            round_sat = {1'b1, HI};
        end
    endfunction

    assign rnd_i = round_sat(acc_i_reg);
    assign rnd_q = round_sat(acc_q_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg   <= 1'b0;
            last_a_reg    <= 1'b0;
            done_b_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg   <= ctrl.valid;
            last_a_reg    <= ctrl.last;
            done_b_reg    <= valid_a_reg && last_a_reg;
            res_valid_reg <= done_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_i_reg <= coef * smp_i;
        prod_q_reg <= coef * smp_q;
        if (ctrl.clear)
        begin
            acc_i_reg <= '0;
            acc_q_reg <= '0;
        end
        else if (valid_a_reg)
        begin
            acc_i_reg <= acc_i_reg + ACC_W'(prod_i_reg);
            acc_q_reg <= acc_q_reg + ACC_W'(prod_q_reg);
        end
        if (done_b_reg)
        begin
            res_i_reg       <= rnd_i[SAMPLE_BITS-1:0];
            res_q_reg       <= rnd_q[SAMPLE_BITS-1:0];
            res_clipped_reg <= rnd_i[SAMPLE_BITS] || rnd_q[SAMPLE_BITS];
        end
    end

    assign res_valid   = res_valid_reg;
    assign res_i       = res_i_reg;
    assign res_q       = res_q_reg;
    assign res_clipped = res_clipped_reg;

endmodule

// ===== src/decimating_complex_fir.sv =====
// Top level of the decimating complex FIR filter with real coefficients.
//
// Input words arrive on s_tvalid/s_tready. s_tuser selects the kind of word: 0 carries
// an I/Q sample, 1 writes one coefficient at coef_index. Output words leave on
// m_tvalid/m_tready, one for every decimation_factor-th sample, with the saturated
// flag in m_tuser. Registers are written through cfg_we/cfg_index/cfg_data.
//
// A coefficient word or a sample that makes no output leaves s_tready high. A sample
// that makes an output starts a filter sum: one multiply-accumulate
// unit serves every tap in turn, one tap per cycle, fed by the delay-line and
// coefficient memories, followed by the product, accumulate and rounding stages.
// s_tready is low while the taps are being summed.
//
// After reset, the block sweeps every address of both memories to zero with
// s_tready low; configuration writes are taken during that sweep.
// A finished word waits in the output register while the receiver stalls. Further
// words are accepted meanwhile, and the block holds a new result until the
// output register is free.
module decimating_complex_fir #(
    parameter  int MAX_TAPS    = dcf_pkg::DEF_MAX_TAPS,
    parameter  int SAMPLE_BITS = dcf_pkg::DEF_SAMPLE_BITS,
    localparam int IN_RAW      = 2 * SAMPLE_BITS + dcf_pkg::IDX_BITS + dcf_pkg::COEF_BITS,
    localparam int IN_W        = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_W       = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sample_i, sample_q, coef_index, coef_value, zero fill
    input  logic [IN_W-1:0]                   s_tdata,
    // func
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_i, out_q, zero fill
    output logic [OUT_W-1:0]                  m_tdata,
    // saturated
    output logic                              m_tuser,
    input  logic                              cfg_we,
    input  logic [dcf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [dcf_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_TAPS);
    localparam int DL_W   = 2 * SAMPLE_BITS;
    localparam int CIX_LO = 2 * SAMPLE_BITS;
    localparam int CV_LO  = CIX_LO + dcf_pkg::IDX_BITS;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_TAPS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_WAIT,
        ST_OUT
    } state_t;

    state_t                            state_reg, state_next;
    logic [ADDR_W-1:0]                 clr_reg, clr_next;
    logic [ADDR_W-1:0]                 wp_reg, wp_next;
    logic [ADDR_W-1:0]                 rp_reg, rp_next;
    logic [ADDR_W-1:0]                 k_reg, k_next;
    logic [ADDR_W-1:0]                 last_k_reg, last_k_next;
    logic [dcf_pkg::PHASE_BITS-1:0]    phase_reg, phase_next;
    logic [dcf_pkg::DECIM_BITS-1:0]    decim_reg;
    logic [dcf_pkg::TAPS_BITS-1:0]     taps_reg;
    logic                              rd_valid_reg, rd_last_reg;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic signed [SAMPLE_BITS-1:0]     out_i_reg, out_q_reg;
    logic                              sat_reg;

    logic [DL_W-1:0]                   dly_mem [MAX_TAPS];
    logic signed [dcf_pkg::COEF_BITS-1:0] coef_mem [MAX_TAPS];
    logic [DL_W-1:0]                   dly_rd_reg;
    logic signed [dcf_pkg::COEF_BITS-1:0] coef_rd_reg;

    logic                              accept;
    logic                              is_sample;
    logic [dcf_pkg::DECIM_BITS-1:0]    factor;
    logic                              make_out;
    logic [ADDR_W-1:0]                 taps_last;
    logic [dcf_pkg::IDX_BITS-1:0]      coef_idx;
    logic                              dly_we, coef_we;
    logic [ADDR_W-1:0]                 dly_wa, coef_wa;
    logic [DL_W-1:0]                   dly_wd;
    logic signed [dcf_pkg::COEF_BITS-1:0] coef_wd;
    logic                              out_free;
    dcf_pkg::mac_ctrl_t                mac_ctrl;
    logic                              res_valid;
    logic signed [SAMPLE_BITS-1:0]     res_i, res_q;
    logic                              res_clipped;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign is_sample = (s_tuser == dcf_pkg::FUNC_SAMPLE);
    assign coef_idx  = s_tdata[CV_LO-1:CIX_LO];
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        priority if (decim_reg == '0)
        begin
            factor = dcf_pkg::DECIM_BITS'(1);
        end
        else if (int'(decim_reg) > dcf_pkg::MAX_DECIM)
        begin
            factor = dcf_pkg::DECIM_BITS'(dcf_pkg::MAX_DECIM);
        end
        else
        begin
            factor = decim_reg;
        end
    end

    assign make_out = ({1'b0, phase_reg} + 9'd1) >= factor;

    always_comb
    begin
        priority if (taps_reg == '0)
        begin
            taps_last = '0;
        end
        else if (int'(taps_reg) > MAX_TAPS)
        begin
            taps_last = LAST_ADDR;
        end
        else
        begin
            taps_last = ADDR_W'(taps_reg - 7'd1);
        end
    end

    // Memory write port selection.
    always_comb
    begin
        dly_we  = 1'b0;
        dly_wa  = wp_reg;
        dly_wd  = s_tdata[DL_W-1:0];
        coef_we = 1'b0;
        coef_wa = ADDR_W'(coef_idx);
        coef_wd = s_tdata[CV_LO+dcf_pkg::COEF_BITS-1:CV_LO];
        if (state_reg == ST_CLEAR)
        begin
            dly_we  = 1'b1;
            dly_wa  = clr_reg;
            dly_wd  = '0;
            coef_we = 1'b1;
            coef_wa = clr_reg;
            coef_wd = '0;
        end
        else if (accept)
        begin
            dly_we  = is_sample;
            coef_we = !is_sample && (int'(coef_idx) < MAX_TAPS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (dly_we)
        begin
            dly_mem[dly_wa] <= dly_wd;
        end
        if (coef_we)
        begin
            coef_mem[coef_wa] <= coef_wd;
        end
        dly_rd_reg  <= dly_mem[rp_reg];
        coef_rd_reg <= coef_mem[k_reg];
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        k_next        = k_reg;
        last_k_next   = last_k_reg;
        phase_next    = phase_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mac_ctrl.clear = 1'b0;
        mac_ctrl.valid = rd_valid_reg;
        mac_ctrl.last  = rd_last_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && is_sample)
                begin
                    wp_next = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
                    if (make_out)
                    begin
                        phase_next     = '0;
                        rp_next        = wp_reg;
                        k_next         = '0;
                        last_k_next    = taps_last;
                        mac_ctrl.clear = 1'b1;
                        state_next     = ST_MAC;
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
            end
            ST_MAC:
            begin
                rp_next = (rp_reg == '0) ? LAST_ADDR : rp_reg - 1'b1;
                k_next  = k_reg + 1'b1;
                if (k_reg == last_k_reg)
                begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (res_valid)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            wp_reg       <= '0;
            rp_reg       <= '0;
            k_reg        <= '0;
            last_k_reg   <= '0;
            phase_reg    <= '0;
            decim_reg    <= dcf_pkg::DECIM_BITS'(1);
            taps_reg     <= dcf_pkg::TAPS_BITS'(64);
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            k_reg        <= k_next;
            last_k_reg   <= last_k_next;
            phase_reg    <= phase_next;
            rd_valid_reg <= (state_reg == ST_MAC);
            rd_last_reg  <= (state_reg == ST_MAC) && (k_reg == last_k_reg);
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dcf_pkg::CFG_DECIMATION: decim_reg <= cfg_data;
                    dcf_pkg::CFG_TAP_COUNT:  taps_reg  <= cfg_data[dcf_pkg::TAPS_BITS-1:0];
                    default:                 decim_reg <= decim_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            out_i_reg <= res_i;
            out_q_reg <= res_q;
            sat_reg   <= res_clipped;
        end
    end

    dcf_mac #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (mac_ctrl),
        .coef        (coef_rd_reg),
        .smp_i       (dly_rd_reg[SAMPLE_BITS-1:0]),
        .smp_q       (dly_rd_reg[DL_W-1:SAMPLE_BITS]),
        .res_valid   (res_valid),
        .res_i       (res_i),
        .res_q       (res_q),
        .res_clipped (res_clipped)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({out_q_reg, out_i_reg});
    assign m_tuser  = sat_reg;

`ifndef NO_ASSERTIONS
    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= LAST_ADDR)
        else $error("write position out of range");

    a_res_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> state_reg == ST_WAIT)
        else $error("filter result outside of the wait state");

    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MAC |-> k_reg <= last_k_reg)
        else $error("tap counter ran past the last tap");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> m_tvalid)
        else $error("output word not presented after load");
`endif

endmodule

// ===== tb/dcf_output_checker.sv =====
// Output checker for the decimating complex FIR filter: predicts and compares every output word.
module dcf_output_checker
    import dcf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [55:0]              s_tdata,
    input  logic                     s_tuser,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [31:0]              m_tdata,
    input  logic                     m_tuser,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       outstanding,
    output int                       mismatches,
    output int                       words_checked
);

    localparam int TAPS = DEF_MAX_TAPS;
    localparam int SB   = DEF_SAMPLE_BITS;
    localparam int IN_W = 56;

    localparam logic signed [47:0] ROUND_HALF = 48'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [47:0] SAT_HI     = (48'sd1 <<< (SB - 1)) - 48'sd1;
    localparam logic signed [47:0] SAT_LO     = -SAT_HI - 48'sd1;

    typedef struct packed {
        logic [SB-1:0] out_i;
        logic [SB-1:0] out_q;
        logic          saturated;
    } filtered_word_t;

    logic signed [SB-1:0]        line_i [TAPS];
    logic signed [SB-1:0]        line_q [TAPS];
    logic signed [COEF_BITS-1:0] coefs  [TAPS];
    logic [IDX_BITS-1:0]         wr_pos;
    logic [PHASE_BITS-1:0]       phase;
    logic [DECIM_BITS-1:0]       decim_reg;
    logic [TAPS_BITS-1:0]        taps_reg;
    filtered_word_t              filtered_q [$];
    int                          errors_seen = 0;
    int                          words_seen  = 0;

    function automatic logic [SB:0] round_clip(input logic signed [47:0] acc);
        logic signed [47:0] q;
        q = (acc + ROUND_HALF) >>> FRAC_BITS;
        if (q > SAT_HI)
            return {1'b1, SAT_HI[SB-1:0]};
        if (q < SAT_LO)
            return {1'b1, SAT_LO[SB-1:0]};
        return {1'b0, q[SB-1:0]};
    endfunction

    task automatic report_mismatch(input string what);
        errors_seen++;
        $display("Mismatch on output word %0d: %s", words_seen, what);
    endtask

    task automatic absorb_word(input logic func, input logic [IN_W-1:0] data);
        logic signed [47:0] acc_i;
        logic signed [47:0] acc_q;
        logic signed [47:0] c;
        logic signed [47:0] xi;
        logic signed [47:0] xq;
        logic [IDX_BITS-1:0] pos;
        logic [SB:0]         ri;
        logic [SB:0]         rq;
        int                  eff_decim;
        int                  eff_taps;
        int                  k;
        filtered_word_t      w;
        if (func == FUNC_COEF)
        begin
            coefs[data[2*SB +: IDX_BITS]] = data[2*SB+IDX_BITS +: COEF_BITS];
        end
        else
        begin
            line_i[wr_pos] = data[0 +: SB];
            line_q[wr_pos] = data[SB +: SB];
            eff_decim = (decim_reg == 0) ? 1 : ((decim_reg > MAX_DECIM) ? MAX_DECIM : decim_reg);
            if (phase + 1 < eff_decim)
            begin
                phase = phase + 1'b1;
            end
            else
            begin
                phase = '0;
                eff_taps = (taps_reg == 0) ? 1 : ((taps_reg > TAPS) ? TAPS : taps_reg);
                acc_i = '0;
                acc_q = '0;
                for (k = 0; k < eff_taps; k++)
                begin
                    pos   = wr_pos - IDX_BITS'(k);
                    c     = coefs[k];
                    xi    = line_i[pos];
                    xq    = line_q[pos];
                    acc_i = acc_i + c * xi;
                    acc_q = acc_q + c * xq;
                end
                ri = round_clip(acc_i);
                rq = round_clip(acc_q);
                w.out_i     = ri[SB-1:0];
                w.out_q     = rq[SB-1:0];
                w.saturated = ri[SB] | rq[SB];
                filtered_q.push_back(w);
            end
            wr_pos = wr_pos + 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        int n;
        filtered_word_t want;
        if (!rst_n)
        begin
            for (n = 0; n < TAPS; n++)
            begin
                line_i[n] = '0;
                line_q[n] = '0;
                coefs[n]  = '0;
            end
            wr_pos    = '0;
            phase     = '0;
            decim_reg = DECIM_BITS'(1);
            taps_reg  = TAPS_BITS'(TAPS);
            filtered_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_DECIMATION)
                    decim_reg = cfg_data[DECIM_BITS-1:0];
                else if (cfg_index == CFG_TAP_COUNT)
                    taps_reg = cfg_data[TAPS_BITS-1:0];
            end
            if (m_tvalid && m_tready)
            begin
                if (filtered_q.size() == 0)
                begin
                    report_mismatch($sformatf("word %h/%b arrived with nothing expected",
                                              m_tdata, m_tuser));
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (m_tdata[0 +: SB] !== want.out_i)
                        report_mismatch($sformatf("out_i %h, expected %h",
                                                  m_tdata[0 +: SB], want.out_i));
                    if (m_tdata[SB +: SB] !== want.out_q)
                        report_mismatch($sformatf("out_q %h, expected %h",
                                                  m_tdata[SB +: SB], want.out_q));
                    if (m_tuser !== want.saturated)
                        report_mismatch($sformatf("saturated %b, expected %b",
                                                  m_tuser, want.saturated));
                end
                words_seen++;
            end
            if (s_tvalid && s_tready)
                absorb_word(s_tuser, s_tdata);
        end
        outstanding   <= filtered_q.size();
        mismatches    <= errors_seen;
        words_checked <= words_seen;
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the testbench for the decimating complex FIR filter: stimulus, handshakes and verdict.
module tb_top;
    import dcf_pkg::*;

    localparam int SB            = DEF_SAMPLE_BITS;
    localparam int IN_RAW        = 2 * SB + IDX_BITS + COEF_BITS;
    localparam int IN_W          = 56;
    localparam int OUT_W         = 32;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_W-1:0]          s_tdata = '0;
    logic                     s_tuser = FUNC_SAMPLE;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_W-1:0]         m_tdata;
    logic                     m_tuser;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_DECIMATION;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int outstanding;
    int mismatches;
    int words_checked;
    int words_sent    = 0;
    int coef_words    = 0;
    int settings_used = 0;
    int cycle_count   = 0;
    bit calm          = 1'b0;
    bit hold_off      = 1'b0;
    bit hold_done     = 1'b0;

    decimating_complex_fir dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dcf_output_checker filter_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .outstanding   (outstanding),
        .mismatches    (mismatches),
        .words_checked (words_checked)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles without draining.", CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // The receiver stalls at random, and once holds off long enough to back the block up.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                m_tready <= calm || ($urandom_range(99) >= 6);
            end
        end
    end

    function automatic logic [IN_W-1:0] pack_word(input logic [SB-1:0] si,
                                                  input logic [SB-1:0] sq,
                                                  input logic [IDX_BITS-1:0] idx,
                                                  input logic [COEF_BITS-1:0] cv);
        return {{(IN_W - IN_RAW){1'b0}}, cv, idx, sq, si};
    endfunction

    function automatic logic [COEF_BITS-1:0] random_coef();
        if ($urandom_range(3) == 0)
            return COEF_BITS'($urandom);
        return COEF_BITS'($urandom_range(8191) - 4096);
    endfunction

    task automatic send_word(input logic func, input logic [IN_W-1:0] data);
        while (!calm && $urandom_range(99) < 6)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
    endtask

    task automatic send_sample(input logic [SB-1:0] si, input logic [SB-1:0] sq);
        send_word(FUNC_SAMPLE, pack_word(si, sq, IDX_BITS'($urandom), COEF_BITS'($urandom)));
    endtask

    task automatic send_coef(input logic [IDX_BITS-1:0] idx, input logic [COEF_BITS-1:0] cv);
        send_word(FUNC_COEF, pack_word(SB'($urandom), SB'($urandom), idx, cv));
        coef_words++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_settings(input int decim, input int taps);
        settle();
        write_reg(CFG_DECIMATION, CFG_DATA_BITS'(decim));
        write_reg(CFG_TAP_COUNT, {2'($urandom_range(3)), TAPS_BITS'(taps)});
        settings_used++;
    endtask

    task automatic run_random(input int decim, input int taps, input int count,
                              input bit calm_phase, input bit pressure_phase);
        int i;
        apply_settings(decim, taps);
        calm <= calm_phase;
        for (i = 0; i < count; i++)
        begin
            if (pressure_phase && i == 8)
                hold_off <= 1'b1;
            if ($urandom_range(99) < 10)
                send_coef(IDX_BITS'($urandom), random_coef());
            else
                send_sample(SB'($urandom), SB'($urandom));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        apply_settings(1, 64);
        send_coef(6'd0, 16'h7fff);
        send_coef(6'd1, 16'h8000);
        send_coef(6'd63, 16'h8000);
        send_sample(16'h7fff, 16'h8000);
        send_sample(16'h8000, 16'h7fff);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h0001, 16'hffff);

        // A single unit tap shows rounding of exact halves in both directions.
        apply_settings(1, 1);
        send_coef(6'd0, 16'h0001);
        send_sample(16'd16384, 16'hc000);
        send_sample(16'd16383, 16'hbfff);
        send_coef(6'd0, 16'h7fff);
        send_sample(16'h7fff, 16'h8000);

        apply_settings(0, 0);
        send_sample(16'h1234, 16'hedcb);
        send_coef(6'd5, 16'h4000);
        send_sample(16'h7fff, 16'h7fff);

        apply_settings(2, 127);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h0001);
        send_sample(16'h4000, 16'hc000);
        send_sample(16'hffff, 16'h0000);

        run_random(3, 64, 16, 1'b0, 1'b0);
        run_random(1, 17, 36, 1'b0, 1'b1);
        run_random(16, 64, 32, 1'b1, 1'b0);
        run_random(511, 127, 300, 1'b0, 1'b0);
        run_random(4, 33, 10, 1'b0, 1'b0);
        run_random(1, 1, 10, 1'b0, 1'b0);
        run_random(2, 50, 10, 1'b0, 1'b0);
        run_random(7, 40, 12, 1'b0, 1'b0);

        settle();
        $display("Sent %0d input words, %0d of them coefficient writes, over %0d settings.",
                 words_sent, coef_words, settings_used);
        $display("Checked %0d output words across decimation 1 to 256 with back-pressure.",
                 words_checked);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/dcf_pkg.sv
src/dcf_mac.sv
src/decimating_complex_fir.sv
tb/dcf_output_checker.sv
tb/tb_top.sv
